// ----- hdl/wudp_pkg.sv -----
// shared constants and types for the windowed up/down points block
package wudp_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    localparam int PRICE_W    = 32;
    localparam int WL_W       = 9;
    localparam int PS_W       = 20;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_SIZE    = 1'd1;

    localparam logic [WL_W-1:0] WL_RESET = 9'd14;
    localparam logic [PS_W-1:0] PS_RESET = 20'd10;

    // signed points per bar
    localparam int PT_W = 24;
    localparam logic [PRICE_W-1:0] PT_POS_MAX = PRICE_W'((64'd1 << (PT_W - 1)) - 64'd1);
    localparam logic [PRICE_W-1:0] PT_NEG_MAX = PRICE_W'(64'd1 << (PT_W - 1));

    // sums hold the window exactly, down magnitude can reach MAX_WINDOW * 2^(PT_W-1)
    localparam int SUM_W = PT_W + IDX_W;
    localparam int TOT_W = SUM_W + 1;

    localparam int NET_W   = 32;
    localparam int DOWN_W  = 31;
    localparam int RATIO_W = 17;

    // shared divider
    localparam int Q_W       = PRICE_W;
    localparam int DIV_CNT_W = $clog2(Q_W + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_BAR   = DIV_CNT_W'(Q_W);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_RATIO = DIV_CNT_W'(RATIO_W);

    typedef struct packed {
        logic                 load;
        logic                 skip_first;
        logic [DIV_CNT_W-1:0] steps;
    } div_cmd_t;

endpackage

// ----- hdl/windowed_up_down_points.sv -----
// windowed up/down point sums over price bars, top level
//
// usage:
// - input channel (in_valid/in_ready) takes one bar: open_price and close_price
//   in price ticks. output channel (out_valid/out_ready) returns one result per
//   bar: window_full, net_points, down_points, ratio_defined, up_ratio.
// - config port: cfg_write with cfg_index 0 sets window_length (also restarts
//   the window fill), index 1 sets point_size. write only while idle.
// - the shared serial divider does the bulk of the work: 32 steps for the bar
//   change over point_size and 17 for the Q1.16 up ratio, a done strobe after
//   each, plus ring read, sum update and result load. the ratio division is
//   skipped when the ratio is undefined and while the window fills. one bar
//   is in work at a time: the next bar waits until the last one is finished.
// - in_ready is high only while the sequencer is idle; a finished result sits
//   in the output register, so the next bar is accepted while it waits.
// - if the receiver stalls, the next result waits in the sequencer until the
//   output register frees; no result is dropped.
// - reset clears the window (sums, fill count, ring pointer) and restores
//   window_length 14 and point_size 10; the ring contents are not cleared.
module windowed_up_down_points
    import wudp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PRICE_W-1:0]        open_price,
    input  logic [PRICE_W-1:0]        close_price,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      window_full,
    output logic signed [NET_W-1:0]   net_points,
    output logic [DOWN_W-1:0]         down_points,
    output logic                      ratio_defined,
    output logic [RATIO_W-1:0]        up_ratio
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV_BAR = 3'd1;
    localparam logic [2:0] S_SUB     = 3'd2;
    localparam logic [2:0] S_ADD     = 3'd3;
    localparam logic [2:0] S_RAT_LD  = 3'd4;
    localparam logic [2:0] S_DIV_RAT = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    localparam int EXT_W = (SUM_W + 2 > 34) ? SUM_W + 2 : 34;
    localparam logic signed [EXT_W-1:0] NET_HI = EXT_W'(64'sd2147483647);
    localparam logic signed [EXT_W-1:0] NET_LO = ~NET_HI;

    logic [2:0]         state_reg, state_next;
    logic [WL_W-1:0]    wl_reg;
    logic [PS_W-1:0]    ps_reg;
    logic [IDX_W-1:0]   wi_reg;
    logic [CNT_W-1:0]   seen_reg;
    logic [SUM_W-1:0]   up_reg, up_next;
    logic [SUM_W-1:0]   dn_reg, dn_next;
    logic               neg_reg;
    logic [PT_W-1:0]    pt_reg;
    logic               full_reg;
    logic               tot_nz_reg;

    logic               out_valid_reg;
    logic               window_full_reg;
    logic [NET_W-1:0]   net_points_reg;
    logic [DOWN_W-1:0]  down_points_reg;
    logic               ratio_defined_reg;
    logic [RATIO_W-1:0] up_ratio_reg;

    logic [CNT_W-1:0]   eff_w;
    logic [PS_W-1:0]    ps_eff;
    logic [CNT_W:0]     old_sum;
    logic [IDX_W-1:0]   old_addr;
    logic [IDX_W-1:0]   wi_inc;
    logic [PT_W-1:0]    ring_rd;
    logic [PT_W-1:0]    old_mag;
    logic [PT_W-1:0]    new_mag;
    logic [SUM_W-1:0]   old_mag_ext;
    logic [SUM_W-1:0]   new_mag_ext;
    logic [TOT_W-1:0]   tot;
    logic [PRICE_W-1:0] price_diff;
    logic               price_neg;
    logic [PRICE_W-1:0] bar_sat;
    logic [PT_W-1:0]    bar_pt;
    logic               in_fire;
    logic               out_free;
    logic               wl_write;

    logic signed [EXT_W-1:0] up_ext;
    logic signed [EXT_W-1:0] dn_ext;
    logic signed [EXT_W-1:0] net_ext;
    logic [NET_W-1:0]        net_sat;
    logic [DOWN_W-1:0]       dn_sat;

    div_cmd_t           div_cmd;
    logic [TOT_W-1:0]   div_rem_init;
    logic [Q_W-1:0]     div_quo_init;
    logic [TOT_W-1:0]   div_divisor;
    logic               div_done;
    logic [Q_W-1:0]     div_quo;

    function automatic logic [PT_W-1:0] pt_mag(input logic [PT_W-1:0] p);
        pt_mag = p[PT_W-1] ? (~p + 1'b1) : p;
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign wl_write = cfg_write && (cfg_index == CFG_WINDOW_LENGTH);

    // effective window and divisor
    always_comb
    begin
        if (wl_reg == '0)
        begin
            eff_w = CNT_W'(1);
        end
        else if (32'(wl_reg) > 32'(MAX_WINDOW))
        begin
            eff_w = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_w = CNT_W'(wl_reg);
        end
        ps_eff = (ps_reg == '0) ? PS_W'(1) : ps_reg;
    end

    // slot leaving the window, modulo the ring depth
    always_comb
    begin
        old_sum = (CNT_W+1)'(wi_reg) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(eff_w);
        if (old_sum >= (CNT_W+1)'(MAX_WINDOW))
        begin
            old_sum = old_sum - (CNT_W+1)'(MAX_WINDOW);
        end
        old_addr = old_sum[IDX_W-1:0];
        wi_inc   = (wi_reg == IDX_W'(MAX_WINDOW - 1)) ? '0 : wi_reg + 1'b1;
    end

    wudp_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (state_reg == S_ADD),
        .wr_addr (wi_reg),
        .wr_data (pt_reg),
        .rd_addr (old_addr),
        .rd_data (ring_rd)
    );

    always_comb
    begin
        price_neg  = (close_price < open_price);
        price_diff = price_neg ? (open_price - close_price) : (close_price - open_price);
        if (neg_reg)
        begin
            bar_sat = (div_quo > PT_NEG_MAX) ? PT_NEG_MAX : div_quo;
            bar_pt  = PT_W'(~bar_sat + 1'b1);
        end
        else
        begin
            bar_sat = (div_quo > PT_POS_MAX) ? PT_POS_MAX : div_quo;
            bar_pt  = PT_W'(bar_sat);
        end
        old_mag     = pt_mag(ring_rd);
        new_mag     = pt_mag(pt_reg);
        old_mag_ext = SUM_W'(old_mag);
        new_mag_ext = SUM_W'(new_mag);
        tot         = TOT_W'(up_reg) + TOT_W'(dn_reg);
    end

    // divider command by sequencer state
    always_comb
    begin
        div_cmd.load       = 1'b0;
        div_cmd.skip_first = 1'b0;
        div_cmd.steps      = DIV_STEPS_BAR;
        div_rem_init       = '0;
        div_quo_init       = price_diff;
        div_divisor        = TOT_W'(ps_eff);
        if (state_reg == S_IDLE)
        begin
            div_cmd.load = in_fire;
        end
        else if (state_reg == S_RAT_LD)
        begin
            div_cmd.load       = (tot != '0);
            div_cmd.skip_first = 1'b1;
            div_cmd.steps      = DIV_STEPS_RATIO;
            div_rem_init       = TOT_W'(up_reg);
            div_quo_init       = '0;
            div_divisor        = tot;
        end
    end

    wudp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .quo_init (div_quo_init),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DIV_BAR;
                end
            end
            S_DIV_BAR:
            begin
                if (div_done)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = (seen_reg >= eff_w) ? S_RAT_LD : S_FIN;
            end
            S_RAT_LD:
            begin
                state_next = (tot != '0) ? S_DIV_RAT : S_FIN;
            end
            S_DIV_RAT:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // window sums: drop the leaving bar, then add the new one; wl_write clears both
    always_comb
    begin
        up_next = up_reg;
        dn_next = dn_reg;
        if (state_reg == S_SUB && seen_reg >= eff_w)
        begin
            if (ring_rd[PT_W-1])
            begin
                dn_next = (dn_reg >= old_mag_ext) ? dn_reg - old_mag_ext : '0;
            end
            else
            begin
                up_next = (up_reg >= old_mag_ext) ? up_reg - old_mag_ext : '0;
            end
        end
        else if (state_reg == S_ADD)
        begin
            if (pt_reg[PT_W-1])
            begin
                dn_next = dn_reg + new_mag_ext;
            end
            else
            begin
                up_next = up_reg + new_mag_ext;
            end
        end
        if (wl_write)
        begin
            up_next = '0;
            dn_next = '0;
        end
    end

    always_comb
    begin
        up_ext  = EXT_W'(up_reg);
        dn_ext  = EXT_W'(dn_reg);
        net_ext = up_ext - dn_ext;
        if (net_ext > NET_HI)
        begin
            net_sat = NET_W'(NET_HI);
        end
        else if (net_ext < NET_LO)
        begin
            net_sat = NET_W'(NET_LO);
        end
        else
        begin
            net_sat = NET_W'(net_ext);
        end
        dn_sat = (dn_ext > NET_HI) ? DOWN_W'(NET_HI) : DOWN_W'(dn_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wl_reg        <= WL_RESET;
            ps_reg        <= PS_RESET;
            wi_reg        <= '0;
            seen_reg      <= '0;
            up_reg        <= '0;
            dn_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            up_reg    <= up_next;
            dn_reg    <= dn_next;
            if (cfg_write && cfg_index == CFG_POINT_SIZE)
            begin
                ps_reg <= cfg_data[PS_W-1:0];
            end
            if (wl_write)
            begin
                wl_reg   <= cfg_data[WL_W-1:0];
                seen_reg <= '0;
            end
            else if (state_reg == S_SUB && seen_reg < eff_w)
            begin
                seen_reg <= seen_reg + 1'b1;
            end
            if (state_reg == S_ADD)
            begin
                wi_reg <= wi_inc;
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            neg_reg <= price_neg;
        end
        if (state_reg == S_DIV_BAR && div_done)
        begin
            pt_reg <= bar_pt;
        end
        if (state_reg == S_ADD)
        begin
            full_reg   <= (seen_reg >= eff_w);
            tot_nz_reg <= 1'b0;
        end
        if (state_reg == S_RAT_LD)
        begin
            tot_nz_reg <= (tot != '0);
        end
        if (state_reg == S_FIN && out_free)
        begin
            window_full_reg   <= full_reg;
            net_points_reg    <= full_reg ? net_sat : '0;
            down_points_reg   <= full_reg ? dn_sat : '0;
            ratio_defined_reg <= tot_nz_reg;
            up_ratio_reg      <= tot_nz_reg ? div_quo[RATIO_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window_full   = window_full_reg;
    assign net_points    = net_points_reg;
    assign down_points   = down_points_reg;
    assign ratio_defined = ratio_defined_reg;
    assign up_ratio      = up_ratio_reg;

`ifndef SYNTH
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= eff_w)
        else $error("window fill count beyond window length");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_BAR || state_reg == S_DIV_RAT))
        else $error("divider finished outside a wait state");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result shown without finishing a transaction");

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (up_ratio_reg <= RATIO_W'(65536)))
        else $error("up ratio above one");

    a_ratio_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(ratio_defined_reg && !window_full_reg))
        else $error("ratio reported before the window filled");
`endif

endmodule

// ----- hdl/wudp_ram.sv -----
// generic single write port, single read port ram with registered read
module wudp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/wudp_div.sv -----
// shared restoring divider, one quotient bit per cycle
module wudp_div
    import wudp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_cmd_t         cmd,
    input  logic [TOT_W-1:0] rem_init,
    input  logic [Q_W-1:0]   quo_init,
    input  logic [TOT_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);

    logic [TOT_W-1:0]     rem_reg, rem_next;
    logic [Q_W-1:0]       quo_reg, quo_next;
    logic [TOT_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 skip_reg, skip_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TOT_W:0]       trial;
    logic [TOT_W:0]       diff;
    logic                 ge;

    // first step of a ratio divides the preloaded remainder without shifting
    always_comb
    begin
        trial = skip_reg ? {1'b0, rem_reg} : {rem_reg, quo_reg[Q_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        skip_next = skip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.load)
        begin
            rem_next  = rem_init;
            quo_next  = quo_init;
            cnt_next  = cmd.steps;
            skip_next = cmd.skip_first;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
            quo_next  = {quo_reg[Q_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            skip_next = 1'b0;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            skip_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            skip_reg <= skip_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTH
    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy_reg)
        else $error("divider loaded while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !skip_reg) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule
